FILE: hw/rtl/keyed_clock_system_register_block_assert.svh
// Assertion macros shared by the clock system register block RTL.
`ifndef KEYED_CLOCK_SYSTEM_REGISTER_BLOCK_ASSERT_SVH
`define KEYED_CLOCK_SYSTEM_REGISTER_BLOCK_ASSERT_SVH
`ifndef SYNTHESIS
`define KCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCS_ASSERT(lbl, prop, msg)
`define KCS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/kcs_pkg.sv
// Package with the types, codes and frequency tables of the clock system register block.
package kcs_pkg;

  localparam int NUM_REGS = 7;
  localparam int FREQ_W   = 25;

  typedef logic [15:0]       ctrl_word_t;
  typedef logic [FREQ_W-1:0] hz_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] REG_KEY  = 3'd0;
  localparam logic [2:0] REG_DCO  = 3'd1;
  localparam logic [2:0] REG_SEL  = 3'd2;
  localparam logic [2:0] REG_DIV  = 3'd3;
  localparam logic [2:0] REG_CTL4 = 3'd4;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam logic [7:0] KEY_HI    = 8'hA5;
  localparam logic [7:0] LOCKED_HI = 8'h96;

  localparam logic [2:0] SRC_LFXT  = 3'd0;
  localparam logic [2:0] SRC_VLO   = 3'd1;
  localparam logic [2:0] SRC_LFMOD = 3'd2;
  localparam logic [2:0] SRC_MOD   = 3'd4;

  localparam hz_t VLO_HZ   = 25'd10000;
  localparam hz_t LFXT_HZ  = 25'd32768;
  localparam hz_t LFMOD_HZ = 25'd39062;
  localparam hz_t MOD_HZ   = 25'd5000000;

  localparam hz_t DCO_RST_HZ  = 25'd8000000;
  localparam hz_t MAIN_RST_HZ = 25'd1000000;
  localparam hz_t SUB_RST_HZ  = 25'd1000000;
  localparam hz_t AUX_RST_HZ  = 25'd10000;

  localparam ctrl_word_t CTRL_RST [NUM_REGS] = '{
    16'h9600, 16'h000C, 16'h0033, 16'h0033, 16'hCDC9, 16'h00C5, 16'h0000
  };

  typedef struct packed {
    ctrl_word_t dco_ctl;
    ctrl_word_t sel_ctl;
    ctrl_word_t div_ctl;
    logic       lf_vlo;
  } kcs_clk_cfg_t;

  typedef struct packed {
    hz_t dco;
    hz_t main;
    hz_t sub;
    hz_t aux;
  } kcs_freqs_t;

  function automatic hz_t dco_low_hz(input logic [2:0] idx);
    case (idx)
      3'd0: dco_low_hz = 25'd1000000;
      3'd1: dco_low_hz = 25'd2670000;
      3'd2: dco_low_hz = 25'd3500000;
      3'd3: dco_low_hz = 25'd4000000;
      3'd4: dco_low_hz = 25'd5330000;
      3'd5: dco_low_hz = 25'd7000000;
      default: dco_low_hz = 25'd8000000;
    endcase
  endfunction

  function automatic hz_t dco_high_hz(input logic [2:0] idx);
    case (idx)
      3'd0: dco_high_hz = 25'd1000000;
      3'd1: dco_high_hz = 25'd5330000;
      3'd2: dco_high_hz = 25'd7000000;
      3'd3: dco_high_hz = 25'd8000000;
      3'd4: dco_high_hz = 25'd16000000;
      3'd5: dco_high_hz = 25'd21000000;
      default: dco_high_hz = 25'd24000000;
    endcase
  endfunction

endpackage

FILE: hw/rtl/kcs_freq.sv
// Frequency calculation for the DCO and the main, sub and auxiliary clocks.
module kcs_freq
  import kcs_pkg::*;
(
  input  kcs_clk_cfg_t cfg,
  output kcs_freqs_t   freqs
);

  hz_t dco_hz;

  function automatic hz_t src_hz(input logic [2:0] sel, input hz_t dco, input logic lf_vlo);
    case (sel)
      SRC_LFXT:  src_hz = lf_vlo ? VLO_HZ : LFXT_HZ;
      SRC_VLO:   src_hz = VLO_HZ;
      SRC_LFMOD: src_hz = LFMOD_HZ;
      SRC_MOD:   src_hz = MOD_HZ;
      default:   src_hz = dco;
    endcase
  endfunction

  always_comb begin
    dco_hz = cfg.dco_ctl[6] ? dco_high_hz(cfg.dco_ctl[3:1]) : dco_low_hz(cfg.dco_ctl[3:1]);
    freqs.dco  = dco_hz;
    freqs.main = src_hz(cfg.sel_ctl[2:0], dco_hz, cfg.lf_vlo) >> cfg.div_ctl[2:0];
    freqs.sub  = src_hz(cfg.sel_ctl[6:4], dco_hz, cfg.lf_vlo) >> cfg.div_ctl[6:4];
    freqs.aux  = src_hz(cfg.sel_ctl[10:8], dco_hz, cfg.lf_vlo) >> cfg.div_ctl[10:8];
  end

endmodule

FILE: hw/rtl/keyed_clock_system_register_block.sv
// Top level of the keyed clock system register block.
//
//   port group | dir | transfer when          | payload
//   in_*       | in  | in_valid && !in_stall  | op, reg_offset, is_word, write_data
//   out_*      | out | out_valid && !out_stall| read_data and DCO, main, sub, aux frequencies
//
// Each access's result is registered at the edge that takes it; unless stalled, a new
// access can be taken every cycle. The register file, lock flag and frequencies update
// at that same edge. Input stalls only while a held result is itself stalled.
// Synchronous active-low reset restores the register defaults and locks the block.
module keyed_clock_system_register_block
  import kcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [3:0]  in_reg_offset,
  input  logic        in_is_word,
  input  logic [15:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic [24:0] out_dco_hz,
  output logic [24:0] out_main_clock_hz,
  output logic [24:0] out_sub_clock_hz,
  output logic [24:0] out_aux_clock_hz
);

`include "keyed_clock_system_register_block_assert.svh"

  ctrl_word_t   ctrl_r [NUM_REGS];
  ctrl_word_t   ctrl_nxt [NUM_REGS];
  logic         unlocked_r, unlocked_nxt;
  kcs_freqs_t   freq_r, freq_nxt;
  logic         out_valid_r, out_valid_nxt;
  ctrl_word_t   rd_r, rd_nxt;
  kcs_freqs_t   ofreq_r;

  logic         in_fire;
  logic [2:0]   idx;
  ctrl_word_t   old_word;
  ctrl_word_t   merged;
  logic         wr_en;
  logic         recompute;
  logic         key_wr;
  logic         key_set;
  logic         key_match;
  logic         locked_wr;
  kcs_clk_cfg_t clk_cfg;
  kcs_freqs_t   calc_freqs;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign idx      = in_reg_offset[3:1];

  assign key_wr    = in_fire && (in_op == OP_WRITE) && (idx == REG_KEY);
  assign key_set   = key_wr && (in_is_word || in_reg_offset[0]);
  assign key_match = in_is_word ? (in_write_data[15:8] == KEY_HI)
                                : (in_write_data[7:0] == KEY_HI);
  assign locked_wr = in_fire && (in_op == OP_WRITE) && (idx != REG_KEY) && !unlocked_r;

  always_comb begin
    old_word = (idx == REG_NONE) ? 16'h0000 : ctrl_r[idx];
    if (in_is_word) begin
      merged = in_write_data;
    end else if (in_reg_offset[0]) begin
      merged = {in_write_data[7:0], old_word[7:0]};
    end else begin
      merged = {old_word[15:8], in_write_data[7:0]};
    end
    wr_en = in_fire && (in_op == OP_WRITE) && (idx != REG_NONE)
            && ((idx == REG_KEY) || unlocked_r);
    recompute = wr_en && ((idx == REG_DCO) || (idx == REG_SEL) || (idx == REG_DIV));
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      ctrl_nxt[i] = ctrl_r[i];
    end
    if (wr_en) begin
      ctrl_nxt[idx] = merged;
    end
    unlocked_nxt = key_set ? key_match : unlocked_r;
  end

  always_comb begin
    clk_cfg.dco_ctl = ctrl_nxt[REG_DCO];
    clk_cfg.sel_ctl = ctrl_nxt[REG_SEL];
    clk_cfg.div_ctl = ctrl_nxt[REG_DIV];
    clk_cfg.lf_vlo  = ctrl_r[REG_CTL4][0];
  end

  kcs_freq u_freq (
    .cfg   (clk_cfg),
    .freqs (calc_freqs)
  );

  assign freq_nxt = recompute ? calc_freqs : freq_r;

  always_comb begin
    rd_nxt = 16'h0000;
    if (in_op == OP_READ) begin
      if (idx == REG_KEY) begin
        rd_nxt = {(unlocked_r ? KEY_HI : LOCKED_HI), ctrl_r[REG_KEY][7:0]};
      end else begin
        rd_nxt = old_word;
      end
    end
    out_valid_nxt = in_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= CTRL_RST[i];
      end
      unlocked_r  <= 1'b0;
      freq_r      <= '{dco: DCO_RST_HZ, main: MAIN_RST_HZ, sub: SUB_RST_HZ, aux: AUX_RST_HZ};
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= ctrl_nxt[i];
      end
      unlocked_r  <= unlocked_nxt;
      freq_r      <= freq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r    <= rd_nxt;
      ofreq_r <= freq_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = rd_r;
  assign out_dco_hz        = ofreq_r.dco;
  assign out_main_clock_hz = ofreq_r.main;
  assign out_sub_clock_hz  = ofreq_r.sub;
  assign out_aux_clock_hz  = ofreq_r.aux;

  `KCS_ASSERT_RST(a_reset_locks, !rst_n |=> !unlocked_r && !out_valid_r, "reset did not lock")
  `KCS_ASSERT(a_fire_gives_result, in_fire |=> out_valid_r, "accepted access gave no result")
  `KCS_ASSERT(a_locked_no_recompute, locked_wr |=> $stable(freq_r), "locked write retuned")
  `KCS_ASSERT(a_key_unlocks, key_set && key_match |=> unlocked_r, "key write did not unlock")

endmodule
